// ===== hdl/sav_pkg.sv =====
// shared constants for the seek-and-arrive steering pipeline
`timescale 1ns / 1ps
package sav_pkg;
  localparam int unsigned MS_W      = 23;  // max_speed width
  localparam int unsigned TS_W      = 16;  // time_step width
  localparam int unsigned TH_W      = 16;  // arrive_threshold width
  localparam int unsigned TS_FRAC   = 16;  // fraction bits of time_step
  localparam int unsigned QUO_W     = 23;  // quotient bits of every divider
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_TH = 2'd2;

  localparam logic [MS_W-1:0] MAX_SPEED_RST = 23'd25600;
  localparam logic [TS_W-1:0] TIME_STEP_RST = 16'd1092;
  localparam logic [TH_W-1:0] ARRIVE_TH_RST = 16'd1;
  // values derived from the reset registers
  localparam logic [MS_W-1:0]   REACH_RST  = 23'd426;
  localparam logic [2*MS_W-1:0] REACH2_RST = 46'd181476;
  localparam logic [2*TH_W-1:0] THR2_RST   = 32'd1;
endpackage

// ===== hdl/sav_sqrt_cell.sv =====
// one digit step of the integer square root chain
`timescale 1ns / 1ps
module sav_sqrt_cell #(
  parameter int unsigned RW = 25
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [2*RW-1:0] rad_i,
  input  logic [RW+1:0]   rem_i,
  input  logic [RW-1:0]   root_i,
  output logic [2*RW-1:0] rad_o,
  output logic [RW+1:0]   rem_o,
  output logic [RW-1:0]   root_o
);
  logic [RW+3:0]   r2;
  logic [RW+3:0]   trial;
  logic            ge;
  logic [2*RW-1:0] rad_d;
  logic [RW+1:0]   rem_d;
  logic [RW-1:0]   root_d;

  always_comb begin
    r2     = {rem_i, rad_i[2*RW-1 -: 2]};
    trial  = (RW+4)'({root_i, 2'b01});
    ge     = (r2 >= trial);
    rem_d  = ge ? (RW+2)'(r2 - trial) : (RW+2)'(r2);
    root_d = {root_i[RW-2:0], ge};
    rad_d  = {rad_i[2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_o  <= '0;
      rem_o  <= '0;
      root_o <= '0;
    end else if (en_i) begin
      rad_o  <= rad_d;
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end
endmodule

// ===== hdl/sav_div_cell.sv =====
// one quotient bit of a restoring divider chain
`timescale 1ns / 1ps
module sav_div_cell #(
  parameter int unsigned DW = 16,
  parameter int unsigned QB = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QB-1:0] low_i,
  input  logic [QB-1:0] quo_i,
  input  logic [DW-1:0] div_i,
  output logic [DW-1:0] rem_o,
  output logic [QB-1:0] low_o,
  output logic [QB-1:0] quo_o,
  output logic [DW-1:0] div_o
);
  logic [DW:0] r2;
  logic        ge;

  always_comb begin
    r2 = {rem_i, low_i[QB-1]};
    ge = (r2 >= {1'b0, div_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_o <= '0;
      low_o <= '0;
      quo_o <= '0;
      div_o <= '0;
    end else if (en_i) begin
      rem_o <= ge ? DW'(r2 - {1'b0, div_i}) : DW'(r2);
      low_o <= {low_i[QB-2:0], 1'b0};
      quo_o <= {quo_i[QB-2:0], ge};
      div_o <= div_i;
    end
  end
endmodule

// ===== hdl/seek_arrive_velocity.sv =====
// seek-with-arrival steering: agent, goal and goal velocity in, new velocity out
// usage:
// - input stream s_axis carries agent_x, agent_y, target_x, target_y,
//   target_vel_x, target_vel_y; output stream m_axis carries vel_x, vel_y in
//   tdata and the arrived flag in tuser
// - cfg port writes max_speed, time_step, arrive_threshold by index; cfg_ready_o
//   is always high, writes only while the pipeline is empty
// - one request per cycle sustained while the output is not stalled; the path runs
//   through the square root chain (POS_WIDTH + 1 cells) and two 23-cell divider
//   chains, plus entry, multiply and output stages
// - the whole chain moves as one: when the output holds an untaken result the
//   chain freezes and s_axis_tready drops until m_axis_tready returns
// - reset clears every valid bit and loads the registers with their defaults;
//   the derived limits (reach, squared threshold) load their reset values too
`timescale 1ns / 1ps
module seek_arrive_velocity #(
  parameter int unsigned POS_WIDTH = 24
) (
  input  logic clk_i,
  input  logic rst_ni,
  // agent_x, agent_y, target_x, target_y, target_vel_x, target_vel_y
  input  logic [((6*POS_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // vel_x, vel_y
  output logic [((2*POS_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // arrived
  output logic [0:0]                       m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sav_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [sav_pkg::CFG_DAT_W-1:0]         cfg_data_i
);
  localparam int unsigned P     = POS_WIDTH;
  localparam int unsigned RW    = P + 1;          // root and |d| width
  localparam int unsigned SQ_W  = 2 * P + 2;      // squared distance width
  localparam int unsigned QB    = sav_pkg::QUO_W;
  localparam int unsigned MS_W  = sav_pkg::MS_W;
  localparam int unsigned TS_W  = sav_pkg::TS_W;
  localparam int unsigned CW    = (SQ_W > 2 * MS_W) ? SQ_W : 2 * MS_W;
  localparam int unsigned SN_W  = RW + sav_pkg::TS_FRAC;   // speed dividend
  localparam int unsigned PN_W  = MS_W + RW;              // product dividend
  localparam int unsigned SW    = ((P > QB) ? P : QB) + 1; // saturation compare

  typedef struct packed {
    logic          vld;
    logic          arr;
    logic          near;
    logic          negx;
    logic          negy;
    logic [RW-1:0] adx;
    logic [RW-1:0] ady;
    logic [P-1:0]  tvx;
    logic [P-1:0]  tvy;
    logic [RW-1:0] dlen;
  } sb_t;

  // configuration registers
  logic [MS_W-1:0]          max_speed_q;
  logic [TS_W-1:0]          time_step_q;
  logic [sav_pkg::TH_W-1:0] arrive_th_q;
  logic [MS_W-1:0]          reach_q;
  logic [2*MS_W-1:0]        reach2_q;
  logic [2*sav_pkg::TH_W-1:0] thr2_q;

  logic en;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= sav_pkg::MAX_SPEED_RST;
      time_step_q <= sav_pkg::TIME_STEP_RST;
      arrive_th_q <= sav_pkg::ARRIVE_TH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sav_pkg::REG_MAX_SPEED: max_speed_q <= cfg_data_i[MS_W-1:0];
        sav_pkg::REG_TIME_STEP: time_step_q <= cfg_data_i[TS_W-1:0];
        sav_pkg::REG_ARRIVE_TH: arrive_th_q <= cfg_data_i[sav_pkg::TH_W-1:0];
        default: ;
      endcase
    end
  end

  // derived limits, one multiplier per register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_q  <= sav_pkg::REACH_RST;
      reach2_q <= sav_pkg::REACH2_RST;
      thr2_q   <= sav_pkg::THR2_RST;
    end else begin
      reach_q  <= MS_W'(({16'd0, max_speed_q} * {23'd0, time_step_q}) >> sav_pkg::TS_FRAC);
      reach2_q <= {{MS_W{1'b0}}, reach_q} * {{MS_W{1'b0}}, reach_q};
      thr2_q   <= {{sav_pkg::TH_W{1'b0}}, arrive_th_q} * {{sav_pkg::TH_W{1'b0}}, arrive_th_q};
    end
  end

  // the whole chain advances unless the output register is stuck
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage a: differences and magnitudes
  logic signed [P-1:0] ax, ay, gx, gy;
  logic signed [P:0]   dx, dy;
  sb_t                 a_sb;

  always_comb begin
    ax = s_axis_tdata[0*P +: P];
    ay = s_axis_tdata[1*P +: P];
    gx = s_axis_tdata[2*P +: P];
    gy = s_axis_tdata[3*P +: P];
    dx = (P+1)'(gx) - (P+1)'(ax);
    dy = (P+1)'(gy) - (P+1)'(ay);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_sb <= '0;
    end else if (en) begin
      a_sb.vld  <= s_axis_tvalid;
      a_sb.arr  <= 1'b0;
      a_sb.near <= 1'b0;
      a_sb.negx <= dx[P];
      a_sb.negy <= dy[P];
      a_sb.adx  <= dx[P] ? RW'(-dx) : RW'(dx);
      a_sb.ady  <= dy[P] ? RW'(-dy) : RW'(dy);
      a_sb.tvx  <= s_axis_tdata[4*P +: P];
      a_sb.tvy  <= s_axis_tdata[5*P +: P];
      a_sb.dlen <= '0;
    end
  end

  // stage b: squares
  sb_t             b_sb;
  logic [SQ_W-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_sb <= '0;
    end else if (en) begin
      b_sb <= a_sb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= a_sb.adx * a_sb.adx;
      sqy_q <= a_sb.ady * a_sb.ady;
    end
  end

  // stage c: squared distance, arrival and one-step reach tests
  logic [SQ_W-1:0] d2;
  sb_t             c_nx;
  sb_t             c_sb;
  logic [SQ_W-1:0] d2_q;

  assign d2 = sqx_q + sqy_q;

  always_comb begin
    c_nx      = b_sb;
    c_nx.arr  = (CW'(d2) <= CW'(thr2_q));
    c_nx.near = (CW'(d2) <= CW'(reach2_q)) && (time_step_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_sb <= '0;
    end else if (en) begin
      c_sb <= c_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) d2_q <= d2;
  end

  // square root chain, one root bit per cell
  logic [2*RW-1:0] sq_rad  [0:RW];
  logic [RW+1:0]   sq_rem  [0:RW];
  logic [RW-1:0]   sq_root [0:RW];
  sb_t             sb1     [0:RW];

  assign sq_rad[0]  = (2*RW)'(d2_q);
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;
  assign sb1[0]     = c_sb;

  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    sav_sqrt_cell #(.RW(RW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sb1[k+1] <= '0;
      else if (en) sb1[k+1] <= sb1[k];
    end
  end

  // near speed = dist * 2^16 / time_step, bounded by max_speed when used
  logic [SN_W-1:0] sp_num;
  logic [TS_W-1:0] sp_rem [0:QB];
  logic [QB-1:0]   sp_low [0:QB];
  logic [QB-1:0]   sp_quo [0:QB];
  logic [TS_W-1:0] sp_div [0:QB];
  sb_t             sb2    [0:QB];

  assign sp_num    = {sq_root[RW], {sav_pkg::TS_FRAC{1'b0}}};
  assign sp_rem[0] = TS_W'(sp_num >> QB);
  assign sp_low[0] = QB'(sp_num);
  assign sp_quo[0] = '0;
  assign sp_div[0] = time_step_q;

  always_comb begin
    sb2[0]      = sb1[RW];
    sb2[0].dlen = sq_root[RW];
  end

  for (genvar k = 0; k < QB; k++) begin : g_spd
    sav_div_cell #(.DW(TS_W), .QB(QB)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .rem_i  (sp_rem[k]),
      .low_i  (sp_low[k]),
      .quo_i  (sp_quo[k]),
      .div_i  (sp_div[k]),
      .rem_o  (sp_rem[k+1]),
      .low_o  (sp_low[k+1]),
      .quo_o  (sp_quo[k+1]),
      .div_o  (sp_div[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sb2[k+1] <= '0;
      else if (en) sb2[k+1] <= sb2[k];
    end
  end

  // multiply stage: speed times each |d|
  logic [MS_W-1:0] speed;
  sb_t             m_sb;
  logic [PN_W-1:0] px_q, py_q;

  assign speed = sb2[QB].near ? sp_quo[QB] : max_speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_sb <= '0;
    else if (en) m_sb <= sb2[QB];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q <= PN_W'(speed) * PN_W'(sb2[QB].adx);
      py_q <= PN_W'(speed) * PN_W'(sb2[QB].ady);
    end
  end

  // component dividers, product / dist, both lanes in step
  logic [RW-1:0] xr [0:QB], yr [0:QB], xv [0:QB], yv [0:QB];
  logic [QB-1:0] xl [0:QB], yl [0:QB], xq [0:QB], yq [0:QB];
  sb_t           sb3 [0:QB];

  assign xr[0]  = RW'(px_q >> QB);
  assign xl[0]  = QB'(px_q);
  assign xq[0]  = '0;
  assign xv[0]  = m_sb.dlen;
  assign yr[0]  = RW'(py_q >> QB);
  assign yl[0]  = QB'(py_q);
  assign yq[0]  = '0;
  assign yv[0]  = m_sb.dlen;
  assign sb3[0] = m_sb;

  for (genvar k = 0; k < QB; k++) begin : g_comp
    sav_div_cell #(.DW(RW), .QB(QB)) u_x (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .rem_i  (xr[k]),
      .low_i  (xl[k]),
      .quo_i  (xq[k]),
      .div_i  (xv[k]),
      .rem_o  (xr[k+1]),
      .low_o  (xl[k+1]),
      .quo_o  (xq[k+1]),
      .div_o  (xv[k+1])
    );
    sav_div_cell #(.DW(RW), .QB(QB)) u_y (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .rem_i  (yr[k]),
      .low_i  (yl[k]),
      .quo_i  (yq[k]),
      .div_i  (yv[k]),
      .rem_o  (yr[k+1]),
      .low_o  (yl[k+1]),
      .quo_o  (yq[k+1]),
      .div_o  (yv[k+1])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sb3[k+1] <= '0;
      else if (en) sb3[k+1] <= sb3[k];
    end
  end

  // sign, saturation and arrival select
  localparam logic [SW-1:0] POS_LIM = SW'({(P-1){1'b1}});

  function automatic logic [P-1:0] sav_sat(input logic [QB-1:0] mag, input logic neg);
    logic [SW-1:0] m;
    logic [P-1:0]  r;
    begin
      m = SW'(mag);
      if (neg) begin
        if (m > POS_LIM) r = {1'b1, {(P-1){1'b0}}};
        else             r = P'(-m);
      end else begin
        if (m > POS_LIM) r = {1'b0, {(P-1){1'b1}}};
        else             r = P'(m);
      end
      sav_sat = r;
    end
  endfunction

  sb_t          z_sb;
  logic [P-1:0] vx_q, vy_q;
  logic         arr_q;

  assign z_sb = sb3[QB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= z_sb.vld;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      arr_q <= z_sb.arr;
      vx_q  <= z_sb.arr ? z_sb.tvx : sav_sat(xq[QB], z_sb.negx);
      vy_q  <= z_sb.arr ? z_sb.tvy : sav_sat(yq[QB], z_sb.negy);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = (((2*P+7)/8)*8)'({vy_q, vx_q});
  assign m_axis_tuser  = arr_q;
endmodule

// ===== hdl/sav_checker.sv =====
// port-level checks for the steering pipeline, bound to the top level
`timescale 1ns / 1ps
module sav_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  // a held result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a stalled output freezes the chain, so no new request may enter
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("request taken while chain frozen");

  // a reset clears any offered result
  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result during reset");
endmodule

bind seek_arrive_velocity sav_checker u_sav_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== sim/tb_seek_arrive_velocity.sv =====
// testbench for the seek-with-arrival steering pipeline
`timescale 1ns / 1ps
module tb_seek_arrive_velocity;
  localparam int PW = 24;
  localparam int LATENCY = PW + 52;

  typedef struct packed {
    logic signed [PW-1:0] tvy;
    logic signed [PW-1:0] tvx;
    logic signed [PW-1:0] ty;
    logic signed [PW-1:0] tx;
    logic signed [PW-1:0] ay;
    logic signed [PW-1:0] ax;
  } steer_req_t;

  typedef struct packed {
    logic                 arrived;
    logic signed [PW-1:0] vy;
    logic signed [PW-1:0] vx;
  } steer_vel_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [143:0] s_axis_tdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [sav_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [sav_pkg::CFG_DAT_W-1:0] cfg_data_i = '0;

  // model copy of the registers
  logic [sav_pkg::MS_W-1:0] speed_lim = sav_pkg::MAX_SPEED_RST;
  logic [sav_pkg::TS_W-1:0] step_dt = sav_pkg::TIME_STEP_RST;
  logic [sav_pkg::TH_W-1:0] arr_thr = sav_pkg::ARRIVE_TH_RST;

  steer_req_t pending_reqs[$];
  steer_vel_t expected_vels[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  seek_arrive_velocity #(.POS_WIDTH(PW)) u_dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // one velocity component: speed * |d| / dist, sign of d, saturated
  function automatic logic signed [PW-1:0] steer_comp(longint unsigned spd, longint d,
                                                     longint unsigned dlen);
    longint unsigned mag;
    longint unsigned ad;
    ad = (d < 0) ? -d : d;
    mag = (dlen != 0) ? (spd * ad) / dlen : 0;
    if (d < 0) begin
      if (mag > 64'd8388608) mag = 64'd8388608;
      return PW'(-longint'(mag));
    end
    if (mag > 64'd8388607) mag = 64'd8388607;
    return PW'(mag);
  endfunction

  function automatic steer_vel_t predict_velocity(steer_req_t r);
    steer_vel_t v;
    longint dx, dy;
    longint unsigned d2, dlen, reach, spd;
    dx = longint'(r.tx) - longint'(r.ax);
    dy = longint'(r.ty) - longint'(r.ay);
    d2 = longint'(dx * dx) + longint'(dy * dy);
    if (d2 <= longint'(arr_thr) * longint'(arr_thr)) begin
      v.vx = r.tvx;
      v.vy = r.tvy;
      v.arrived = 1'b1;
      return v;
    end
    dlen = int_sqrt(d2);
    reach = (longint'(speed_lim) * longint'(step_dt)) >> sav_pkg::TS_FRAC;
    spd = speed_lim;
    if (step_dt != 0 && d2 <= reach * reach) spd = (dlen << sav_pkg::TS_FRAC) / step_dt;
    v.vx = steer_comp(spd, dx, dlen);
    v.vy = steer_comp(spd, dy, dlen);
    v.arrived = 1'b0;
    return v;
  endfunction

  // driver: offer queued requests, predict on acceptance
  always @(posedge clk_i) begin
    steer_req_t r;
    if (s_axis_tvalid && s_axis_tready) begin
      r = steer_req_t'(s_axis_tdata);
      expected_vels.push_back(predict_velocity(r));
      void'(pending_reqs.pop_front());
    end
    if (rst_ni && pending_reqs.size() > 0
        && ($urandom_range(99) >= send_idle_pct || (s_axis_tvalid && !s_axis_tready))) begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= pending_reqs[0];
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk_i) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // monitor: random backpressure plus one long hold-off
  always @(posedge clk_i) begin
    steer_vel_t got, exp_v;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[0], m_axis_tdata[47:24], m_axis_tdata[23:0]};
      if (expected_vels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_v = expected_vels.pop_front();
        if (got !== exp_v) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp vx=%0d vy=%0d arr=%0b got vx=%0d vy=%0d arr=%0b",
                     exp_v.vx, exp_v.vy, exp_v.arrived, got.vx, got.vy, got.arrived);
        end
      end
    end
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [sav_pkg::CFG_IDX_W-1:0] idx,
                           logic [sav_pkg::CFG_DAT_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      sav_pkg::REG_MAX_SPEED: speed_lim = val[sav_pkg::MS_W-1:0];
      sav_pkg::REG_TIME_STEP: step_dt = val[sav_pkg::TS_W-1:0];
      sav_pkg::REG_ARRIVE_TH: arr_thr = val[sav_pkg::TH_W-1:0];
      default: ;
    endcase
  endtask

  // wait until the pipeline has drained, then let derived limits settle
  task automatic drain;
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_vels.size() != 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic signed [PW-1:0] rnd_pos();
    case ($urandom_range(5))
      0: return PW'($urandom);
      1: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return PW'($signed($urandom_range(4000)) - 2000);
    endcase
  endfunction

  task automatic add_req(int ax, int ay, int tx, int ty, int tvx, int tvy);
    steer_req_t r;
    r.ax = PW'(ax); r.ay = PW'(ay); r.tx = PW'(tx); r.ty = PW'(ty);
    r.tvx = PW'(tvx); r.tvy = PW'(tvy);
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(int n);
    steer_req_t r;
    int off;
    repeat (n) begin
      r.ax = rnd_pos();
      r.ay = rnd_pos();
      r.tvx = PW'($urandom);
      r.tvy = PW'($urandom);
      // mostly nearby goals so arrival and one-step reach both occur
      if ($urandom_range(3) != 0) begin
        off = 1 << $urandom_range(12);
        r.tx = r.ax + PW'($signed($urandom_range(2 * off)) - off);
        r.ty = r.ay + PW'($signed($urandom_range(2 * off)) - off);
      end else begin
        r.tx = rnd_pos();
        r.ty = rnd_pos();
      end
      pending_reqs.push_back(r);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // directed: arrival, axis-aligned approaches, extremes, one-step reach
    add_req(0, 0, 0, 0, 24'sh7fffff, -24'sh800000);
    add_req(0, 0, 1, 0, 5, -5);
    add_req(0, 0, 0, 1000, 0, 0);
    add_req(0, 0, 0, -1000, 0, 0);
    add_req(0, 0, 1000, 0, 0, 0);
    add_req(0, 0, -1000, 0, 0, 0);
    add_req(100, 100, 300, 400, 0, 0);
    add_req(-8388608, -8388608, 8388607, 8388607, 0, 0);
    add_req(8388607, 8388607, -8388608, -8388608, -1, -1);
    add_req(8388607, -8388608, -8388608, 8388607, 1, 1);
    add_req(0, 0, 10, -10, 0, 0);
    add_req(0, 0, -300, 200, 0, 0);
    drain();
    write_reg(sav_pkg::REG_MAX_SPEED, 23'h7fffff);
    write_reg(sav_pkg::REG_TIME_STEP, 16'hffff);
    write_reg(sav_pkg::REG_ARRIVE_TH, 16'hffff);
    add_req(0, 0, 65535, 0, 3, 4);
    add_req(0, 0, 65536, 0, 3, 4);
    add_req(-8388608, -8388608, 8388607, 8388607, 0, 0);
    add_req(0, 0, 40000, 50000, 0, 0);
    drain();
    write_reg(sav_pkg::REG_MAX_SPEED, '0);
    write_reg(sav_pkg::REG_TIME_STEP, 16'd1);
    write_reg(sav_pkg::REG_ARRIVE_TH, '0);
    add_req(0, 0, 0, 0, 7, 7);
    add_req(0, 0, 1, 1, 7, 7);
    add_req(5, 5, -500, 900, 7, 7);
    drain();

    // phase 1: sender idles a little, receiver a lot, plus a long hold-off
    send_idle_pct = 10; recv_idle_pct = 70;
    write_reg(sav_pkg::REG_MAX_SPEED, sav_pkg::MAX_SPEED_RST);
    write_reg(sav_pkg::REG_TIME_STEP, sav_pkg::TIME_STEP_RST);
    write_reg(sav_pkg::REG_ARRIVE_TH, 16'd64);
    hold_cycles = 300;
    add_random(450);
    drain();

    // phase 2: the other way round, fresh random settings
    send_idle_pct = 70; recv_idle_pct = 10;
    write_reg(sav_pkg::REG_MAX_SPEED, sav_pkg::CFG_DAT_W'($urandom_range(200000)));
    write_reg(sav_pkg::REG_TIME_STEP, sav_pkg::TS_W'($urandom_range(65535, 1)));
    write_reg(sav_pkg::REG_ARRIVE_TH, sav_pkg::TH_W'($urandom_range(2000)));
    add_random(450);
    drain();

    // phase 3: full rate
    send_idle_pct = 0; recv_idle_pct = 0;
    write_reg(sav_pkg::REG_MAX_SPEED, sav_pkg::CFG_DAT_W'($urandom));
    write_reg(sav_pkg::REG_TIME_STEP, sav_pkg::TS_W'($urandom_range(65535, 1)));
    write_reg(sav_pkg::REG_ARRIVE_TH, sav_pkg::TH_W'($urandom));
    add_random(430);
    drain();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
